>>> src/cq_pkg.sv
// Shared types, constants and helpers for the circular queue.
package cq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W   = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_QRY = 2'd2
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic exec;     // update pointers, write slot, read old head
    logic read;     // read new head and tail slots
  } cq_cmd_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

  // Next slot index, wrapping at the configured capacity.
  function automatic idx_t cq_advance(idx_t i, cnt_t cap);
    cnt_t inc;
    inc = cnt_t'(i) + cnt_t'(1);
    return (inc >= cap) ? '0 : inc[IDX_W-1:0];
  endfunction

  // Clamp a written capacity into 1..DEPTH.
  function automatic cnt_t cq_clamp_cap(cnt_t v);
    cnt_t r;
    r = v;
    if (v == '0) r = cnt_t'(1);
    else if (v > DEPTH_CNT) r = DEPTH_CNT;
    return r;
  endfunction

endpackage

>>> src/cq_ctrl.sv
// Sequencing controller for the circular queue: accept, execute, read, respond.
module cq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output cq_pkg::cq_cmd_t cmd,
  output logic            out_valid
);
  import cq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_READ;
        end
        S_READ: begin
          state_r     <= S_RESP;
          out_valid_r <= 1'b1;
        end
        S_RESP: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.read    = (state_r == S_READ);
  assign out_valid   = out_valid_r;

endmodule

>>> src/cq_dpath.sv
// Datapath for the circular queue: slot memory, pointers, count, capacity, result fields.
module cq_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cq_pkg::cq_cmd_t        cmd,
  input  logic                   cfg_we,
  input  logic [cq_pkg::CNT_W-1:0] cfg_wdata,
  input  logic [cq_pkg::OP_W-1:0]  in_opcode,
  input  logic signed [cq_pkg::WORD_W-1:0] in_data_in,
  output logic                   out_ok,
  output logic signed [cq_pkg::WORD_W-1:0] out_data_out,
  output logic signed [cq_pkg::WORD_W-1:0] out_front_word,
  output logic signed [cq_pkg::WORD_W-1:0] out_rear_word,
  output logic [cq_pkg::CNT_W-1:0] out_occupancy,
  output logic                   out_is_empty,
  output logic                   out_is_full
);
  import cq_pkg::*;

  word_t mem [DEPTH];

  logic [OP_W-1:0] op_r;
  word_t           din_r;
  idx_t            head_r, head_nxt;
  idx_t            tail_r, tail_nxt;
  cnt_t            cnt_r, cnt_nxt;
  cnt_t            cap_r;
  logic            ok_r, ok_nxt;
  logic            dq_ok_r, dq_ok_nxt;
  word_t           dq_r, front_r, rear_r;
  logic            wen;
  idx_t            waddr;
  logic            empty, full;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == cap_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = 1'b1;
    dq_ok_nxt = 1'b0;
    wen       = 1'b0;
    waddr     = empty ? '0 : cq_advance(tail_r, cap_r);
    case (op_r)
      OP_ENQ: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          wen      = 1'b1;
          tail_nxt = waddr;
          if (empty) head_nxt = '0;
          cnt_nxt  = cnt_r + cnt_t'(1);
        end
      end
      OP_DEQ: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          dq_ok_nxt = 1'b1;
          cnt_nxt   = cnt_r - cnt_t'(1);
          if (head_r == tail_r) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = cq_advance(head_r, cap_r);
          end
        end
      end
      default: begin
        ok_nxt = 1'b1;
      end
    endcase
  end

  // Control state: pointers, count, capacity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      cap_r  <= DEPTH_CNT;
    end else if (cfg_we) begin
      cap_r  <= cq_clamp_cap(cfg_wdata);
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      din_r <= word_t'(in_data_in);
    end
    if (cmd.exec) begin
      ok_r    <= ok_nxt;
      dq_ok_r <= dq_ok_nxt;
    end
  end

  // Slot memory: one write port, three registered read ports, two at head and one at tail.
  always_ff @(posedge clk) begin
    if (cmd.exec && wen) mem[waddr] <= din_r;
    if (cmd.exec) dq_r <= mem[head_r];
    if (cmd.read) begin
      front_r <= mem[head_r];
      rear_r  <= mem[tail_r];
    end
  end

  assign out_ok         = ok_r;
  assign out_data_out   = dq_ok_r ? $signed(dq_r) : '0;
  assign out_front_word = empty ? '0 : $signed(front_r);
  assign out_rear_word  = empty ? '0 : $signed(rear_r);
  assign out_occupancy  = cnt_r;
  assign out_is_empty   = empty;
  assign out_is_full    = full;

endmodule

>>> src/circular_queue.sv
// Top level of the circular queue: controller plus datapath.
// Circular queue of signed 32-bit words, capacity 1..16 slots.
// Input: raise start with in_opcode (0 enqueue, 1 dequeue, 2 or 3 query) and
// in_data_in; the transfer happens at a rising edge where start is high and
// busy is low. busy stays high until the result has been shown.
// Output: out_valid is raised once the execute and slot read steps are done and
// is high for exactly one cycle, with ok, dequeued word, front and rear words,
// occupancy and the empty and full flags valid in that cycle. The receiver
// cannot stall it. A new item is accepted only after the execute, slot read
// and respond steps of the last one around the single slot memory.
// Configuration: cfg_we with cfg_wdata sets the capacity (0 taken as 1, above
// 16 taken as 16) and empties the queue; write it only while busy is low.
// Reset (rst_n low, synchronous): queue empty, capacity 16, no result pending.
// Slot contents are not cleared; only written slots are ever reported.
module circular_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cq_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic [cq_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [cq_pkg::WORD_W-1:0]   in_data_in,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic signed [cq_pkg::WORD_W-1:0]   out_data_out,
  output logic signed [cq_pkg::WORD_W-1:0]   out_front_word,
  output logic signed [cq_pkg::WORD_W-1:0]   out_rear_word,
  output logic [cq_pkg::CNT_W-1:0]           out_occupancy,
  output logic                               out_is_empty,
  output logic                               out_is_full
);
  import cq_pkg::*;

  cq_cmd_t cmd;

  cq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  cq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_opcode),
    .in_data_in     (in_data_in),
    .out_ok         (out_ok),
    .out_data_out   (out_data_out),
    .out_front_word (out_front_word),
    .out_rear_word  (out_rear_word),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

`ifndef SYNTH
  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside of a busy window");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_full |-> !out_is_empty && (out_occupancy != '0))
    else $error("queue reported full and empty together");
`endif

endmodule

>>> tb/tb_circular_queue.sv
// Self-checking testbench for the circular queue: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb_circular_queue;
  import cq_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;  // unused opcode, behaves as a query

  typedef struct {
    logic  ok;
    word_t data_out;
    word_t front_word;
    word_t rear_word;
    cnt_t  occupancy;
    logic  is_empty;
    logic  is_full;
  } queue_result_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata  = '0;
  logic              start      = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_opcode  = OP_QRY;
  logic signed [WORD_W-1:0] in_data_in = '0;
  logic              out_valid;
  logic              out_ok;
  logic signed [WORD_W-1:0] out_data_out;
  logic signed [WORD_W-1:0] out_front_word;
  logic signed [WORD_W-1:0] out_rear_word;
  logic [CNT_W-1:0]  out_occupancy;
  logic              out_is_empty;
  logic              out_is_full;

  // Queue mirror kept by the testbench.
  word_t mirror_slots [DEPTH];
  idx_t  mirror_head  = '0;
  idx_t  mirror_tail  = '0;
  bit    mirror_empty = 1'b1;
  cnt_t  mirror_cap   = cnt_t'(DEPTH);

  queue_result_t expected_q[$];
  int sent_cnt      = 0;
  int recv_cnt      = 0;
  int err_cnt       = 0;
  int cfg_writes    = 0;
  int full_rejects  = 0;
  int empty_rejects = 0;

  circular_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_data_out   (out_data_out),
    .out_front_word (out_front_word),
    .out_rear_word  (out_rear_word),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------- queue mirror ----------------

  function automatic void clear_queue();
    mirror_head  = '0;
    mirror_tail  = '0;
    mirror_empty = 1'b1;
  endfunction

  function automatic idx_t next_slot(idx_t i);
    int n;
    n = int'(i) + 1;
    if (n >= int'(mirror_cap)) n = 0;
    return idx_t'(n);
  endfunction

  function automatic cnt_t stored_words();
    int h, t;
    h = int'(mirror_head);
    t = int'(mirror_tail);
    if (mirror_empty) return '0;
    if (t >= h) return cnt_t'(t - h + 1);
    return cnt_t'(int'(mirror_cap) + t - h + 1);
  endfunction

  // Apply one operation to the mirror and return the result it should produce.
  function automatic queue_result_t queue_step(logic [OP_W-1:0] op, word_t data);
    queue_result_t r;
    r.ok       = 1'b1;
    r.data_out = '0;
    if (op == OP_ENQ) begin
      if (stored_words() == mirror_cap) begin
        r.ok = 1'b0;
        full_rejects++;
      end else begin
        if (mirror_empty) begin
          mirror_head = '0;
          mirror_tail = '0;
        end else begin
          mirror_tail = next_slot(mirror_tail);
        end
        mirror_slots[mirror_tail] = data;
        mirror_empty = 1'b0;
      end
    end else if (op == OP_DEQ) begin
      if (mirror_empty) begin
        r.ok = 1'b0;
        empty_rejects++;
      end else begin
        r.data_out = mirror_slots[mirror_head];
        if (mirror_head == mirror_tail) clear_queue();
        else mirror_head = next_slot(mirror_head);
      end
    end
    r.occupancy  = stored_words();
    r.is_empty   = mirror_empty;
    r.is_full    = (r.occupancy == mirror_cap);
    r.front_word = mirror_empty ? word_t'(0) : mirror_slots[mirror_head];
    r.rear_word  = mirror_empty ? word_t'(0) : mirror_slots[mirror_tail];
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string field, word_t want, word_t got);
    $display("[%0t] MISMATCH %s: expected %h got %h (result %0d)",
             $time, field, want, got, recv_cnt);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    queue_result_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_data_out);
      end else begin
        e = expected_q.pop_front();
        if (out_ok !== e.ok) report_mismatch("ok", word_t'(e.ok), word_t'(out_ok));
        if (out_data_out !== e.data_out) report_mismatch("data_out", e.data_out, out_data_out);
        if (out_front_word !== e.front_word)
          report_mismatch("front_word", e.front_word, out_front_word);
        if (out_rear_word !== e.rear_word)
          report_mismatch("rear_word", e.rear_word, out_rear_word);
        if (out_occupancy !== e.occupancy)
          report_mismatch("occupancy", word_t'(e.occupancy), word_t'(out_occupancy));
        if (out_is_empty !== e.is_empty)
          report_mismatch("is_empty", word_t'(e.is_empty), word_t'(out_is_empty));
        if (out_is_full !== e.is_full)
          report_mismatch("is_full", word_t'(e.is_full), word_t'(out_is_full));
      end
      recv_cnt++;
    end
  end

  // ---------------- stimulus helpers ----------------

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, word_t data, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_opcode  <= op;
    in_data_in <= data;
    do @(posedge clk); while (busy);
    expected_q.push_back(queue_step(op, data));
    sent_cnt++;
  endtask

  // Hold off until every pending result has come back.
  task automatic drain();
    start <= 1'b0;
    wait (recv_cnt == sent_cnt);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value == '0) mirror_cap = cnt_t'(1);
    else if (value > cnt_t'(DEPTH)) mirror_cap = cnt_t'(DEPTH);
    else mirror_cap = value;
    clear_queue();
    cfg_writes++;
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_state();
    send_item(OP_QRY, 32'h1234_5678, 0);
    send_item(OP_DEQ, '0, 0);
    send_item(OP_RSVD, 32'hFFFF_FFFF, 1);
  endtask

  task automatic test_extreme_words();
    send_item(OP_ENQ, 32'h7FFF_FFFF, 0);
    send_item(OP_ENQ, 32'h8000_0000, 0);
    send_item(OP_ENQ, 32'hFFFF_FFFF, 2);
    send_item(OP_ENQ, 32'h0000_0000, 0);
    send_item(OP_DEQ, 32'hFFFF_FFFF, 0);
  endtask

  task automatic test_full_and_empty();
    write_capacity(5'd2);
    send_item(OP_ENQ, 32'h0000_0011, 0);
    send_item(OP_ENQ, 32'h0000_0022, 0);
    send_item(OP_ENQ, 32'h0000_0033, 0);
    send_item(OP_DEQ, '0, 0);
    send_item(OP_DEQ, '0, 0);
  endtask

  task automatic test_capacity_clamp();
    write_capacity(5'd0);
    send_item(OP_ENQ, 32'hA5A5_A5A5, 0);
    send_item(OP_ENQ, 32'h5A5A_5A5A, 0);
    send_item(OP_DEQ, '0, 0);
    send_item(OP_DEQ, '0, 0);
    write_capacity(5'd31);
    send_item(OP_ENQ, 32'hDEAD_BEEF, 0);
    send_item(OP_QRY, '0, 0);
  endtask

  task automatic test_config_clears();
    write_capacity(5'd5);
    send_item(OP_QRY, '0, 0);
  endtask

  // Fill to full, drain to empty, repeat; lag the turnaround so rejects occur.
  task automatic test_random_traffic(logic [CNT_W-1:0] cap, int n_items, bit idle_on);
    bit filling;
    int r;
    logic [OP_W-1:0] op;
    filling = 1'b1;
    write_capacity(cap);
    for (int i = 0; i < n_items; i++) begin
      if (filling && stored_words() == mirror_cap && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && mirror_empty && $urandom_range(0, 3) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 72) op = filling ? OP_ENQ : OP_DEQ;
      else if (r < 86) op = filling ? OP_DEQ : OP_ENQ;
      else if (r < 94) op = OP_QRY;
      else op = OP_RSVD;
      if (i == n_items / 2) drain();
      send_item(op, random_word(), idle_on ? random_gap() : 0);
    end
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extreme_words();
    test_full_and_empty();
    test_capacity_clamp();
    test_config_clears();

    test_random_traffic(5'd16, 150, 1'b1);
    test_random_traffic(5'd1, 60, 1'b1);
    test_random_traffic(5'd5, 100, 1'b0);
    test_random_traffic(cnt_t'($urandom_range(2, 15)), 100, 1'b1);
    test_random_traffic(5'd0, 40, 1'b1);
    test_random_traffic(5'd31, 120, 1'b1);
    test_random_traffic(5'd17, 60, 1'b0);
    test_random_traffic(cnt_t'($urandom_range(0, 31)), 80, 1'b1);

    start <= 1'b0;
    for (k = 0; k < 1000 && recv_cnt != sent_cnt; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("results never arrived", word_t'(expected_q.size()), '0);

    $display("Covered %0d operations, %0d results checked, %0d capacity writes",
             sent_cnt, recv_cnt, cfg_writes);
    $display("Enqueues rejected on full: %0d, dequeues rejected on empty: %0d",
             full_rejects, empty_rejects);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/cq_pkg.sv
src/cq_ctrl.sv
src/cq_dpath.sv
src/circular_queue.sv
tb/tb_circular_queue.sv
